/* src/dnv_pkg.sv */
// dnv_pkg: shared types and constants of the domain name validator
// no dependencies; imported by every module under src

package dnv_pkg;

    localparam logic [7:0] NAME_LEN_RESET  = 8'd253;
    localparam logic [5:0] LABEL_LEN_RESET = 6'd63;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [6:0] LABEL_SAT = 7'd127;
    localparam logic [8:0] TOTAL_SAT = 9'd511;
    localparam logic [8:0] DOTS_SAT  = 9'd511;
    localparam logic [7:0] LEN_SAT   = 8'd255;

    typedef enum logic {
        REG_MAX_NAME  = 1'b0,
        REG_MAX_LABEL = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic ws;
        logic dot;
        logic hyphen;
        logic ldh;
    } dnv_class_t;

    typedef struct packed {
        logic       valid_res;
        logic [7:0] name_length;
    } dnv_result_t;

endpackage

/* src/dnv_char_class.sv */
// dnv_char_class: classifies one byte of the name (whitespace, dot, hyphen, ldh)
// depends on dnv_pkg

module dnv_char_class
    import dnv_pkg::*;
(
    input  logic [7:0] ch,
    output dnv_class_t cls
);

    logic is_digit;
    logic is_upper;
    logic is_lower;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign is_upper = (ch >= 8'h41) && (ch <= 8'h5A);
    assign is_lower = (ch >= 8'h61) && (ch <= 8'h7A);

    assign cls.ws     = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign cls.dot    = (ch == CH_DOT);
    assign cls.hyphen = (ch == CH_HYPHEN);
    assign cls.ldh    = is_digit || is_upper || is_lower || (ch == CH_HYPHEN);

endmodule

/* src/dnv_cfg_regs.sv */
// dnv_cfg_regs: apb register file holding the name and label length limits
// depends on dnv_pkg

module dnv_cfg_regs
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  max_name_length,
    output logic [5:0]  max_label_length
);

    logic       name_sel;
    logic [7:0] max_name_length_reg;
    logic [7:0] max_name_length_next;
    logic [5:0] max_label_length_reg;
    logic [5:0] max_label_length_next;
    logic       wr_en;
    cfg_reg_t   reg_sel;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign reg_sel  = cfg_reg_t'(paddr[2]);
    assign name_sel = (reg_sel == REG_MAX_NAME);

    always_comb
    begin
        max_name_length_next  = max_name_length_reg;
        max_label_length_next = max_label_length_reg;
        if (wr_en)
        begin
            if (name_sel)
            begin
                max_name_length_next = pwdata[7:0];
            end
            else
            begin
                max_label_length_next = pwdata[5:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_length_reg  <= NAME_LEN_RESET;
            max_label_length_reg <= LABEL_LEN_RESET;
        end
        else
        begin
            max_name_length_reg  <= max_name_length_next;
            max_label_length_reg <= max_label_length_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (reg_sel)
                REG_MAX_NAME:  prdata = {24'd0, max_name_length_reg};
                REG_MAX_LABEL: prdata = {26'd0, max_label_length_reg};
                default:       prdata = 32'd0;
            endcase
        end
    end

    assign max_name_length  = max_name_length_reg;
    assign max_label_length = max_label_length_reg;

endmodule

/* src/dnv_name_state.sv */
// dnv_name_state: per-name counters and flags, updated once per byte transfer,
// and the verdict on the final byte; depends on dnv_pkg

module dnv_name_state
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        final_byte,
    input  dnv_class_t  cls,
    input  logic [7:0]  max_name_length,
    input  logic [5:0]  max_label_length,
    output logic        push,
    output dnv_result_t res
);

    logic       in_content_reg;
    logic       in_content_next;
    logic [6:0] label_count_reg;
    logic [6:0] label_count_next;
    logic [8:0] total_count_reg;
    logic [8:0] total_count_next;
    logic       prev_hyphen_reg;
    logic       prev_hyphen_next;
    logic       failed_reg;
    logic       failed_next;
    logic [8:0] held_dots_reg;
    logic [8:0] held_dots_next;
    logic       held_space_reg;
    logic       held_space_next;

    logic       in_content_upd;
    logic [6:0] label_upd;
    logic [8:0] total_upd;
    logic       prev_hyphen_upd;
    logic       failed_upd;
    logic [8:0] held_dots_upd;
    logic       held_space_upd;

    logic        held_nz;
    logic        commit_fail;
    logic [6:0]  label_base;
    logic [10:0] total_sum;
    logic [8:0]  total_sat;
    logic        ok;

    assign held_nz     = (held_dots_reg != 9'd0);
    assign commit_fail = held_nz && ((label_count_reg == 7'd0)
                         || (label_count_reg > {1'b0, max_label_length})
                         || prev_hyphen_reg || (held_dots_reg >= 9'd2));
    assign label_base  = held_nz ? 7'd0 : label_count_reg;
    assign total_sum   = {2'b00, total_count_reg} + {2'b00, held_dots_reg} + 11'd1;
    assign total_sat   = (total_sum > {2'b00, TOTAL_SAT}) ? TOTAL_SAT : total_sum[8:0];

    always_comb
    begin
        in_content_upd  = in_content_reg;
        label_upd       = label_count_reg;
        total_upd       = total_count_reg;
        prev_hyphen_upd = prev_hyphen_reg;
        failed_upd      = failed_reg;
        held_dots_upd   = held_dots_reg;
        held_space_upd  = held_space_reg;
        if (cls.ws)
        begin
            if (in_content_reg)
            begin
                held_space_upd = 1'b1;
            end
        end
        else
        begin
            failed_upd     = failed_reg || held_space_reg;
            held_space_upd = 1'b0;
            in_content_upd = 1'b1;
            if (cls.dot)
            begin
                held_dots_upd = (held_dots_reg == DOTS_SAT) ? DOTS_SAT
                                                           : held_dots_reg + 9'd1;
            end
            else
            begin
                // pending dots become a separator before this byte
                failed_upd = failed_reg || held_space_reg || commit_fail || !cls.ldh
                             || ((label_base == 7'd0) && cls.hyphen);
                label_upd       = (label_base == LABEL_SAT) ? LABEL_SAT
                                                            : label_base + 7'd1;
                prev_hyphen_upd = cls.hyphen;
                total_upd       = total_sat;
                held_dots_upd   = 9'd0;
            end
        end
    end

    assign ok = !failed_upd && (total_upd >= 9'd1)
                && (total_upd <= {1'b0, max_name_length})
                && (label_upd >= 7'd1) && (label_upd <= {1'b0, max_label_length})
                && !prev_hyphen_upd;

    assign push            = step && final_byte;
    assign res.valid_res   = ok;
    assign res.name_length = (total_upd > {1'b0, LEN_SAT}) ? LEN_SAT : total_upd[7:0];

    always_comb
    begin
        in_content_next  = in_content_reg;
        label_count_next = label_count_reg;
        total_count_next = total_count_reg;
        prev_hyphen_next = prev_hyphen_reg;
        failed_next      = failed_reg;
        held_dots_next   = held_dots_reg;
        held_space_next  = held_space_reg;
        if (push)
        begin
            in_content_next  = 1'b0;
            label_count_next = 7'd0;
            total_count_next = 9'd0;
            prev_hyphen_next = 1'b0;
            failed_next      = 1'b0;
            held_dots_next   = 9'd0;
            held_space_next  = 1'b0;
        end
        else if (step)
        begin
            in_content_next  = in_content_upd;
            label_count_next = label_upd;
            total_count_next = total_upd;
            prev_hyphen_next = prev_hyphen_upd;
            failed_next      = failed_upd;
            held_dots_next   = held_dots_upd;
            held_space_next  = held_space_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_content_reg  <= 1'b0;
            label_count_reg <= 7'd0;
            total_count_reg <= 9'd0;
            prev_hyphen_reg <= 1'b0;
            failed_reg      <= 1'b0;
            held_dots_reg   <= 9'd0;
            held_space_reg  <= 1'b0;
        end
        else
        begin
            in_content_reg  <= in_content_next;
            label_count_reg <= label_count_next;
            total_count_reg <= total_count_next;
            prev_hyphen_reg <= prev_hyphen_next;
            failed_reg      <= failed_next;
            held_dots_reg   <= held_dots_next;
            held_space_reg  <= held_space_next;
        end
    end

    // trailing whitespace only counts once content has started
    assert property (@(posedge clk) disable iff (!rst_n)
        held_space_reg |-> in_content_reg)
        else $error("held space without content");

    assert property (@(posedge clk) disable iff (!rst_n)
        (failed_reg || held_dots_reg != 9'd0) |-> in_content_reg)
        else $error("failure or dots recorded before content");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (!in_content_reg && total_count_reg == 9'd0 && held_dots_reg == 9'd0))
        else $error("name state not cleared after final byte");

endmodule

/* src/dnv_out_buf.sv */
// dnv_out_buf: result register plus one skid entry on the result channel
// depends on dnv_pkg

module dnv_out_buf
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  dnv_result_t push_data,
    output logic        full,
    output logic        res_valid,
    input  logic        res_stall,
    output dnv_result_t res_data
);

    logic        out_valid_reg;
    logic        out_valid_next;
    dnv_result_t out_data_reg;
    dnv_result_t out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    dnv_result_t skid_data_reg;
    dnv_result_t skid_data_next;
    logic        pop;

    assign pop = out_valid_reg && !res_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && res_stall) |=> skid_valid_reg)
        else $error("result lost while output stalled");

endmodule

/* src/domain_name_validator.sv */
// domain_name_validator: top level of the streaming dns host name checker
// depends on dnv_pkg, dnv_char_class, dnv_cfg_regs, dnv_name_state, dnv_out_buf
//
// usage
// - the name arrives one byte per transfer on ch, final_byte marks its last byte
// - a byte transfer happens when item_valid is high and item_stall is low
// - only the final byte gives a result: valid_res and name_length on the
//   result channel, transferred when res_valid is high and res_stall is low
// - the final byte's result is registered in the result register or skid entry
// - throughput: one byte per cycle while item_stall is low; the per-byte
//   counter and flag update is combinational, so names can follow back to back
// - when the receiver stalls, the result register holds and a skid entry
//   takes one more result; item_stall rises only while that entry is full
// - reset clears all name state and loads the limits 253 and 63
// - write the limits over apb (0x0 name, 0x4 label) only while idle (unenforced)

module domain_name_validator
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  ch,
    input  logic        final_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        valid_res,
    output logic [7:0]  name_length
);

    dnv_class_t  cls;
    dnv_result_t res_new;
    dnv_result_t res_out;
    logic [7:0]  max_name_length;
    logic [5:0]  max_label_length;
    logic        step;
    logic        push;
    logic        buf_full;

    assign item_stall = buf_full;
    assign step       = item_valid && !buf_full;

    dnv_cfg_regs u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_name_length  (max_name_length),
        .max_label_length (max_label_length)
    );

    dnv_char_class u_class (
        .ch  (ch),
        .cls (cls)
    );

    dnv_name_state u_state (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .final_byte       (final_byte),
        .cls              (cls),
        .max_name_length  (max_name_length),
        .max_label_length (max_label_length),
        .push             (push),
        .res              (res_new)
    );

    dnv_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res_new),
        .full      (buf_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_out)
    );

    assign valid_res   = res_out.valid_res;
    assign name_length = res_out.name_length;

endmodule
